// ===== design/csmc_pkg.sv =====
// shared types and constants of the cubic spline monotonicity check unit
package csmc_pkg;

    localparam int COORD_W = 16;
    localparam int PROD_W  = 64;
    localparam int ACC_W   = 67;

    typedef enum logic [1:0] {
        VERDICT_DATA_BAD   = 2'd0,
        VERDICT_SPLINE_BAD = 2'd1,
        VERDICT_MONOTONE   = 2'd2,
        VERDICT_STRICT     = 2'd3
    } verdict_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_EVAL,
        ST_MUL_A,
        ST_MUL_B,
        ST_LOAD_B,
        ST_RANGE,
        ST_SQ0,
        ST_SQ1,
        ST_SQ2,
        ST_SQ3,
        ST_SQ4,
        ST_SQ5,
        ST_ACC_LAST,
        ST_DECIDE,
        ST_FINISH
    } state_t;

    // operand pairs for the shared multiplier
    typedef enum logic [2:0] {
        MUL_S0DX,
        MUL_S1DX,
        MUL_AA2,
        MUL_AB2,
        MUL_BB,
        MUL_DD9,
        MUL_AD8,
        MUL_BD6
    } mul_sel_t;

    typedef struct packed {
        logic     cap;
        logic     eval;
        logic     mul_go;
        mul_sel_t mul_sel;
        logic     a_load;
        logic     b_load;
        logic     range_chk;
        logic     acc_clr;
        logic     acc_add;
        logic     decide;
        logic     commit;
    } cmd_t;

    typedef struct packed {
        logic have_prev;
        logic need_mul;
        logic in_range;
        logic last;
    } status_t;

endpackage

// ===== design/csmc_knot_if.sv =====
// knot channel: one spline knot per transaction
interface csmc_knot_if;
    import csmc_pkg::*;

    logic                      valid;
    logic                      ready;
    logic signed [COORD_W-1:0] knot_x;
    logic signed [COORD_W-1:0] knot_y;
    logic signed [COORD_W-1:0] knot_slope;
    logic                      last_knot;

    modport source (output valid, knot_x, knot_y, knot_slope, last_knot, input ready);
    modport sink   (input valid, knot_x, knot_y, knot_slope, last_knot, output ready);
endinterface

// ===== design/csmc_verdict_if.sv =====
// verdict channel: one verdict per knot set
interface csmc_verdict_if;
    logic       valid;
    logic       ready;
    logic [1:0] verdict;

    modport source (output valid, verdict, input ready);
    modport sink   (input valid, verdict, output ready);
endinterface

// ===== design/csmc_datapath.sv =====
// datapath: knot registers, shared multiplier, accumulator and sticky verdict bits
module csmc_datapath (
    input  logic                              clk,
    input  logic                              rst_n,
    input  csmc_pkg::cmd_t                    cmd,
    input  logic signed [csmc_pkg::COORD_W-1:0] knot_x,
    input  logic signed [csmc_pkg::COORD_W-1:0] knot_y,
    input  logic signed [csmc_pkg::COORD_W-1:0] knot_slope,
    input  logic                              last_knot,
    output csmc_pkg::status_t                 st,
    output logic [1:0]                        verdict
);
    import csmc_pkg::*;

    logic [COORD_W-1:0] cur_x_reg, cur_y_reg, cur_s_reg;
    logic [COORD_W-1:0] prev_x_reg, prev_y_reg, prev_s_reg;
    logic               last_reg;
    logic               have_prev_reg, past_first_reg;
    logic               data_bad_reg, spline_bad_reg, strict_ok_reg;
    logic [30:0]        a_reg, b_reg;
    logic [PROD_W-1:0]  prod_reg;
    logic               prod_neg_reg;
    logic [ACC_W-1:0]   acc_reg;
    verdict_t           verdict_reg;

    logic [COORD_W:0]   dx, dy;
    logic               dx_pos, dy_neg, dy_zero, s_neg;
    logic [23:0]        d;
    logic [25:0]        d3;
    logic [26:0]        d6;
    logic [27:0]        d9;
    logic [32:0]        t2;
    logic [31:0]        op_x, op_y;
    logic [PROD_W-1:0]  mul_res;
    logic [ACC_W-1:0]   acc_next;
    logic               in_range, edge_hit, acc_pos, acc_neg, curve_bad;
    verdict_t           verdict_next;

    assign dx = {cur_x_reg[COORD_W-1], cur_x_reg} - {prev_x_reg[COORD_W-1], prev_x_reg};
    assign dy = {cur_y_reg[COORD_W-1], cur_y_reg} - {prev_y_reg[COORD_W-1], prev_y_reg};
    assign dx_pos  = !dx[COORD_W] && (dx != '0);
    assign dy_neg  = dy[COORD_W];
    assign dy_zero = (dy == '0);
    assign s_neg   = prev_s_reg[COORD_W-1] || cur_s_reg[COORD_W-1];

    // dy is positive here, so it fits in 16 unsigned bits; d = 256*dy
    assign d  = {dy[COORD_W-1:0], 8'd0};
    assign d3 = {2'd0, d} + {1'b0, d, 1'b0};
    assign d6 = {2'd0, d, 1'b0} + {1'b0, d, 2'b0};
    assign d9 = {4'd0, d} + {1'b0, d, 3'b0};
    assign t2 = {2'd0, a_reg} + {2'd0, b_reg} - {8'd0, d, 1'b0};

    always_comb
    begin
        case (cmd.mul_sel)
            MUL_S0DX:
            begin
                op_x = {16'd0, prev_s_reg};
                op_y = {16'd0, dx[COORD_W-1:0]};
            end
            MUL_S1DX:
            begin
                op_x = {16'd0, cur_s_reg};
                op_y = {16'd0, dx[COORD_W-1:0]};
            end
            MUL_AA2:
            begin
                op_x = {a_reg, 1'b0};
                op_y = {1'b0, a_reg};
            end
            MUL_AB2:
            begin
                op_x = {a_reg, 1'b0};
                op_y = {1'b0, b_reg};
            end
            MUL_BB:
            begin
                op_x = {1'b0, b_reg};
                op_y = {1'b0, b_reg};
            end
            MUL_DD9:
            begin
                op_x = {8'd0, d};
                op_y = {4'd0, d9};
            end
            MUL_AD8:
            begin
                op_x = {1'b0, a_reg};
                op_y = {5'd0, d, 3'b0};
            end
            MUL_BD6:
            begin
                op_x = {1'b0, b_reg};
                op_y = {5'd0, d6};
            end
            default:
            begin
                op_x = '0;
                op_y = '0;
            end
        endcase
    end

    assign mul_res = {32'd0, op_x} * {32'd0, op_y};

    // acc ends as p - m of the sign test
    assign acc_next = prod_neg_reg ? acc_reg - {3'd0, prod_reg} : acc_reg + {3'd0, prod_reg};

    assign in_range = ({1'b0, a_reg} <= {6'd0, d3}) && ({1'b0, b_reg} <= {6'd0, d3});
    assign edge_hit = (past_first_reg && (a_reg == '0 || a_reg == {5'd0, d3}))
                   || (!last_reg && (b_reg == '0 || b_reg == {5'd0, d3}));
    assign acc_neg  = acc_reg[ACC_W-1];
    assign acc_pos  = !acc_reg[ACC_W-1] && (acc_reg != '0);
    assign curve_bad = t2[32] ? acc_neg : acc_pos;

    always_comb
    begin
        if (data_bad_reg)
            verdict_next = VERDICT_DATA_BAD;
        else if (spline_bad_reg)
            verdict_next = VERDICT_SPLINE_BAD;
        else if (strict_ok_reg)
            verdict_next = VERDICT_STRICT;
        else
            verdict_next = VERDICT_MONOTONE;
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.cap)
        begin
            cur_x_reg <= knot_x;
            cur_y_reg <= knot_y;
            cur_s_reg <= knot_slope;
            last_reg  <= last_knot;
        end
        if (cmd.mul_go)
        begin
            prod_reg     <= mul_res;
            prod_neg_reg <= (cmd.mul_sel == MUL_AD8) || (cmd.mul_sel == MUL_BD6);
        end
        if (cmd.a_load)
            a_reg <= prod_reg[30:0];
        if (cmd.b_load)
            b_reg <= prod_reg[30:0];
        if (cmd.acc_clr)
            acc_reg <= '0;
        else if (cmd.acc_add)
            acc_reg <= acc_next;
        if (cmd.commit && last_reg)
            verdict_reg <= verdict_next;
    end

    // knot history and sticky verdict bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_x_reg     <= '0;
            prev_y_reg     <= '0;
            prev_s_reg     <= '0;
            have_prev_reg  <= 1'b0;
            past_first_reg <= 1'b0;
            data_bad_reg   <= 1'b0;
            spline_bad_reg <= 1'b0;
            strict_ok_reg  <= 1'b1;
        end
        else
        begin
            if (cmd.eval && have_prev_reg)
            begin
                if (dy_neg)
                    data_bad_reg <= 1'b1;
                if (dy_zero && dx_pos)
                    strict_ok_reg <= 1'b0;
                if (dx_pos && !dy_neg && s_neg)
                    spline_bad_reg <= 1'b1;
            end
            if (cmd.range_chk && in_range && edge_hit)
                strict_ok_reg <= 1'b0;
            if (cmd.decide)
            begin
                if (curve_bad)
                    spline_bad_reg <= 1'b1;
                if (acc_reg == '0)
                    strict_ok_reg <= 1'b0;
            end
            if (cmd.commit)
            begin
                if (last_reg)
                begin
                    // set finished: back to the reset state
                    prev_x_reg     <= '0;
                    prev_y_reg     <= '0;
                    prev_s_reg     <= '0;
                    have_prev_reg  <= 1'b0;
                    past_first_reg <= 1'b0;
                    data_bad_reg   <= 1'b0;
                    spline_bad_reg <= 1'b0;
                    strict_ok_reg  <= 1'b1;
                end
                else
                begin
                    prev_x_reg     <= cur_x_reg;
                    prev_y_reg     <= cur_y_reg;
                    prev_s_reg     <= cur_s_reg;
                    have_prev_reg  <= 1'b1;
                    past_first_reg <= past_first_reg || have_prev_reg;
                end
            end
        end
    end

    assign st.have_prev = have_prev_reg;
    assign st.need_mul  = have_prev_reg && dx_pos && !dy_neg && !dy_zero && !s_neg;
    assign st.in_range  = in_range;
    assign st.last      = last_reg;
    assign verdict      = verdict_reg;

endmodule

// ===== design/csmc_controller.sv =====
// controller: sequences one knot through the shared multiplier and holds result valid
module csmc_controller (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              knot_valid,
    output logic              knot_ready,
    output logic              result_valid,
    input  logic              result_ready,
    input  csmc_pkg::status_t st,
    output csmc_pkg::cmd_t    cmd
);
    import csmc_pkg::*;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   finish_ok;

    // a last knot waits while the previous verdict is still unread
    assign finish_ok = !(st.last && out_valid_reg && !result_ready);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
                if (knot_valid)
                    state_next = ST_EVAL;
            ST_EVAL:
                state_next = st.need_mul ? ST_MUL_A : ST_FINISH;
            ST_MUL_A:    state_next = ST_MUL_B;
            ST_MUL_B:    state_next = ST_LOAD_B;
            ST_LOAD_B:   state_next = ST_RANGE;
            ST_RANGE:
                state_next = st.in_range ? ST_FINISH : ST_SQ0;
            ST_SQ0:      state_next = ST_SQ1;
            ST_SQ1:      state_next = ST_SQ2;
            ST_SQ2:      state_next = ST_SQ3;
            ST_SQ3:      state_next = ST_SQ4;
            ST_SQ4:      state_next = ST_SQ5;
            ST_SQ5:      state_next = ST_ACC_LAST;
            ST_ACC_LAST: state_next = ST_DECIDE;
            ST_DECIDE:   state_next = ST_FINISH;
            ST_FINISH:
                if (finish_ok)
                    state_next = ST_IDLE;
            default:     state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd         = '0;
        cmd.mul_sel = MUL_S0DX;
        knot_ready  = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                knot_ready = 1'b1;
                cmd.cap    = knot_valid;
            end
            ST_EVAL:
                cmd.eval = 1'b1;
            ST_MUL_A:
            begin
                cmd.mul_go  = 1'b1;
                cmd.mul_sel = MUL_S0DX;
            end
            ST_MUL_B:
            begin
                cmd.a_load  = 1'b1;
                cmd.mul_go  = 1'b1;
                cmd.mul_sel = MUL_S1DX;
            end
            ST_LOAD_B:
                cmd.b_load = 1'b1;
            ST_RANGE:
            begin
                cmd.range_chk = 1'b1;
                cmd.acc_clr   = 1'b1;
            end
            ST_SQ0:
            begin
                cmd.mul_go  = 1'b1;
                cmd.mul_sel = MUL_AA2;
            end
            ST_SQ1:
            begin
                cmd.acc_add = 1'b1;
                cmd.mul_go  = 1'b1;
                cmd.mul_sel = MUL_AB2;
            end
            ST_SQ2:
            begin
                cmd.acc_add = 1'b1;
                cmd.mul_go  = 1'b1;
                cmd.mul_sel = MUL_BB;
            end
            ST_SQ3:
            begin
                cmd.acc_add = 1'b1;
                cmd.mul_go  = 1'b1;
                cmd.mul_sel = MUL_DD9;
            end
            ST_SQ4:
            begin
                cmd.acc_add = 1'b1;
                cmd.mul_go  = 1'b1;
                cmd.mul_sel = MUL_AD8;
            end
            ST_SQ5:
            begin
                cmd.acc_add = 1'b1;
                cmd.mul_go  = 1'b1;
                cmd.mul_sel = MUL_BD6;
            end
            ST_ACC_LAST:
                cmd.acc_add = 1'b1;
            ST_DECIDE:
                cmd.decide = 1'b1;
            ST_FINISH:
                cmd.commit = finish_ok;
            default:
                cmd = '0;
        endcase
    end

    assign out_valid_next = (out_valid_reg && !result_ready) || (cmd.commit && st.last);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign result_valid = out_valid_reg;

endmodule

// ===== design/cubic_spline_monotonicity_check_unit.sv =====
// top level of the cubic spline monotonicity check unit
// Knots (x, y, slope, last mark) come in one per transaction and one verdict goes out per
// set, at its last knot: data non-monotone, spline non-monotone, monotone or strictly
// monotone. One knot is in work at a time. The first knot of a set and a knot whose
// interval needs no ratio test pass EVAL and FINISH; one whose ratios fall inside the
// simple region also passes MUL_A, MUL_B, LOAD_B and RANGE, and one that needs the full
// sign test also SQ0 to SQ5, ACC_LAST and DECIDE. The single 32x32 multiplier computes
// the two ratio products and then the six terms of the sign test one per cycle into a
// 67-bit accumulator. The verdict sits in an output register, so knots keep flowing while
// it waits to be taken; only a following last knot holds until the previous verdict is read.
module cubic_spline_monotonicity_check_unit (
    input  logic                clk,
    input  logic                rst_n,
    csmc_knot_if.sink           knot,
    csmc_verdict_if.source      result
);
    import csmc_pkg::*;

    cmd_t    cmd;
    status_t st;

    csmc_controller u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .knot_valid   (knot.valid),
        .knot_ready   (knot.ready),
        .result_valid (result.valid),
        .result_ready (result.ready),
        .st           (st),
        .cmd          (cmd)
    );

    csmc_datapath u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .knot_x     (knot.knot_x),
        .knot_y     (knot.knot_y),
        .knot_slope (knot.knot_slope),
        .last_knot  (knot.last_knot),
        .st         (st),
        .verdict    (result.verdict)
    );

    // multiplier is only used when there is an interval to test
    a_mul_needs_prev: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.mul_go |-> st.have_prev)
        else $error("multiplier started without a previous knot");

    // a verdict must never overwrite one that is still unread
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.commit && st.last) |-> !(result.valid && !result.ready))
        else $error("verdict overwritten before it was taken");

    // a verdict appears only after a last knot was committed
    a_valid_from_commit: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result.valid) |-> $past(cmd.commit && st.last))
        else $error("verdict valid without a finished set");

    // no knot accepted while one is in work
    a_one_in_work: assert property (@(posedge clk) disable iff (!rst_n)
        (knot.valid && knot.ready) |=> !knot.ready)
        else $error("knot accepted while another was in work");

endmodule

// ===== tb/sv/csmc_check_pkg.sv =====
`timescale 1ns / 1ps
// verdict predictor and scoreboard for the spline monotonicity check testbench
package csmc_check_pkg;
    import csmc_pkg::*;

    class verdict_board;
        logic signed [COORD_W-1:0] prev_x;
        logic signed [COORD_W-1:0] prev_y;
        logic signed [COORD_W-1:0] prev_slope;
        bit       have_prev;
        bit       past_first;
        bit       data_fault;
        bit       spline_fault;
        bit       strict_hold;
        verdict_t pending_verdicts[$];
        int       errors;
        int       knots;
        int       sets;
        int       tally[4];

        function new();
            errors = 0;
            knots  = 0;
            sets   = 0;
            foreach (tally[i]) tally[i] = 0;
            restart_set();
        endfunction

        function void restart_set();
            prev_x       = '0;
            prev_y       = '0;
            prev_slope   = '0;
            have_prev    = 1'b0;
            past_first   = 1'b0;
            data_fault   = 1'b0;
            spline_fault = 1'b0;
            strict_hold  = 1'b1;
        endfunction

        // one interval between the stored knot and the new one
        function void judge_interval(input logic signed [COORD_W-1:0] x1, y1, s1,
                                     input bit chk_m0, chk_m1);
            longint dx, dy, s0, sn, d, d3, a, b, t2;
            logic signed [127:0] wa, wb, wd, lin, poly;
            int sgn;
            dx = longint'(x1) - longint'(prev_x);
            dy = longint'(y1) - longint'(prev_y);
            s0 = longint'(prev_slope);
            sn = longint'(s1);
            if (dy < 0)
                data_fault = 1'b1;
            if (dy == 0 && dx > 0)
                strict_hold = 1'b0;
            if (dx <= 0 || dy < 0)
                return;
            if (s0 < 0 || sn < 0)
            begin
                spline_fault = 1'b1;
                return;
            end
            if (dy == 0)
                return;
            d  = dy * 256;
            a  = s0 * dx;
            b  = sn * dx;
            d3 = 3 * d;
            if (a <= d3 && b <= d3)
            begin
                if (chk_m0 && (a == 0 || a == d3))
                    strict_hold = 1'b0;
                if (chk_m1 && (b == 0 || b == d3))
                    strict_hold = 1'b0;
            end
            else
            begin
                // outside the box: sign of the ellipse test, exact in wide integers
                wa   = a;
                wb   = b;
                wd   = d;
                lin  = 8 * wa * wd + 6 * wb * wd;
                poly = 2 * wa * wa + 2 * wa * wb + wb * wb + 9 * wd * wd;
                sgn  = (lin > poly) ? 1 : ((lin == poly) ? 0 : -1);
                t2   = a + b - 2 * d;
                if (t2 >= 0 ? (sgn < 0) : (sgn > 0))
                    spline_fault = 1'b1;
                if (sgn == 0)
                    strict_hold = 1'b0;
            end
        endfunction

        function void note_knot(input logic signed [COORD_W-1:0] x, y, s, input logic last);
            verdict_t v;
            knots++;
            if (have_prev)
            begin
                judge_interval(x, y, s, past_first, !last);
                past_first = 1'b1;
            end
            prev_x     = x;
            prev_y     = y;
            prev_slope = s;
            have_prev  = 1'b1;
            if (last)
            begin
                if (data_fault)
                    v = VERDICT_DATA_BAD;
                else if (spline_fault)
                    v = VERDICT_SPLINE_BAD;
                else if (strict_hold)
                    v = VERDICT_STRICT;
                else
                    v = VERDICT_MONOTONE;
                pending_verdicts.push_back(v);
                restart_set();
            end
        endfunction

        function void check_verdict(input logic [1:0] got);
            verdict_t want;
            if (pending_verdicts.size() == 0)
            begin
                errors++;
                $error("verdict: expected none, actual %0d", got);
                return;
            end
            want = pending_verdicts.pop_front();
            sets++;
            tally[int'(want)]++;
            if (got !== want)
            begin
                errors++;
                $error("verdict: expected %0d (%s), actual %0d", want, want.name(), got);
            end
        endfunction
    endclass

endpackage

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps
// top of the testbench for the cubic spline monotonicity check unit
module tb;
    import csmc_pkg::*;
    import csmc_check_pkg::*;

    localparam int TOTAL_KNOTS = 1950;
    localparam int HOLD_CYCLES = 400;
    localparam int IDLE_LIMIT  = 4000;
    localparam int TAIL_CYCLES = 40;

    logic clk = 1'b0;
    logic rst_n;
    bit   calm_sender;
    int   knots_sent;

    verdict_board board;

    csmc_knot_if    knot_ch();
    csmc_verdict_if verdict_ch();

    cubic_spline_monotonicity_check_unit u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .knot   (knot_ch),
        .result (verdict_ch)
    );

    always #10 clk = ~clk;

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (knot_ch.valid && knot_ch.ready)
                board.note_knot(knot_ch.knot_x, knot_ch.knot_y, knot_ch.knot_slope,
                                knot_ch.last_knot);
            if (verdict_ch.valid && verdict_ch.ready)
                board.check_verdict(verdict_ch.verdict);
        end
    end

    // watchdog on cycles with no transaction on either channel
    initial
    begin
        int idle;
        idle = 0;
        while (idle < IDLE_LIMIT)
        begin
            @(posedge clk);
            if ((knot_ch.valid && knot_ch.ready) || (verdict_ch.valid && verdict_ch.ready))
                idle = 0;
            else
                idle++;
        end
        $display("end of test: mismatches");
        $finish;
    end

    // verdict receiver: random stalls, a calm window, long hold-offs after some verdicts
    initial
    begin
        int taken;
        int cyc;
        taken = 0;
        cyc   = 0;
        verdict_ch.ready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            cyc++;
            if (verdict_ch.valid && verdict_ch.ready)
            begin
                taken++;
                if (taken == 25 || taken == 250)
                begin
                    verdict_ch.ready <= 1'b0;
                    repeat (HOLD_CYCLES) @(posedge clk);
                end
            end
            verdict_ch.ready <= (cyc > 3000 && cyc < 8000) ? 1'b1 : ($urandom_range(99) >= 10);
        end
    end

    task automatic send_knot(input logic signed [COORD_W-1:0] x, y, s, input logic last);
        while (!calm_sender && $urandom_range(99) < 10)
        begin
            knot_ch.valid <= 1'b0;
            @(posedge clk);
        end
        knot_ch.valid      <= 1'b1;
        knot_ch.knot_x     <= x;
        knot_ch.knot_y     <= y;
        knot_ch.knot_slope <= s;
        knot_ch.last_knot  <= last;
        @(posedge clk);
        while (!knot_ch.ready)
            @(posedge clk);
        knots_sent++;
    endtask

    // mostly rising knot sets with slopes near the secant, some pure noise
    task automatic random_set();
        int len;
        int kind;
        int i;
        int x;
        int y;
        int dx;
        int dy;
        int base;
        int s;
        len  = ($urandom_range(9) == 0) ? int'($urandom_range(9, 20)) : int'($urandom_range(1, 6));
        kind = $urandom_range(99);
        x    = int'($urandom_range(0, 24000)) - 32768;
        y    = int'($urandom_range(0, 24000)) - 32768;
        base = 256;
        for (i = 0; i < len; i++)
        begin
            if (kind < 75)
            begin
                if (i > 0)
                begin
                    if ($urandom_range(19) == 0)
                        dx = -int'($urandom_range(0, 50));
                    else
                        dx = int'($urandom_range(1, 2500));
                    if ($urandom_range(9) == 0)
                        dy = 0;
                    else if ($urandom_range(29) == 0)
                        dy = -int'($urandom_range(1, 500));
                    else
                        dy = int'($urandom_range(1, 2500));
                    x    = x + dx;
                    y    = y + dy;
                    base = (dx > 0 && dy > 0) ? (dy * 256) / dx : 64;
                    if (base > 32767)
                        base = 32767;
                end
                s = base * int'($urandom_range(0, 45)) / 10;
                if (s > 32767)
                    s = 32767;
                if ($urandom_range(24) == 0)
                    s = -s - 1;
            end
            else
            begin
                x = $urandom;
                y = $urandom;
                s = $urandom;
            end
            send_knot(x[15:0], y[15:0], s[15:0], i == len - 1);
        end
    endtask

    initial
    begin
        board               = new();
        rst_n               = 1'b0;
        calm_sender         = 1'b0;
        knots_sent          = 0;
        knot_ch.valid       = 1'b0;
        knot_ch.knot_x      = '0;
        knot_ch.knot_y      = '0;
        knot_ch.knot_slope  = '0;
        knot_ch.last_knot   = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // single knot sets at the field extremes
        send_knot(-16'sd32768, -16'sd32768, -16'sd32768, 1'b1);
        send_knot(16'sd32767, 16'sd32767, 16'sd32767, 1'b1);
        // strictly monotone, ratio one everywhere
        send_knot(0, 0, 256, 1'b0);
        send_knot(256, 256, 256, 1'b0);
        send_knot(512, 512, 256, 1'b1);
        // zero slope at the outer ends is still strict
        send_knot(0, 0, 0, 1'b0);
        send_knot(256, 256, 0, 1'b1);
        // zero slope at an inner knot
        send_knot(0, 0, 256, 1'b0);
        send_knot(256, 256, 0, 1'b0);
        send_knot(512, 512, 256, 1'b1);
        // ratio exactly three
        send_knot(0, 0, 768, 1'b0);
        send_knot(256, 256, 768, 1'b0);
        send_knot(512, 512, 768, 1'b1);
        // decreasing y, and data fault winning over a negative slope
        send_knot(0, 256, 0, 1'b0);
        send_knot(256, 0, 0, 1'b1);
        send_knot(0, 0, -5, 1'b0);
        send_knot(256, 256, 100, 1'b0);
        send_knot(512, 0, 100, 1'b1);
        // x standing still then going back: spline test skipped
        send_knot(256, 0, 256, 1'b0);
        send_knot(256, 256, 256, 1'b0);
        send_knot(0, 512, 256, 1'b1);
        // flat intervals, with and without a negative slope
        send_knot(0, 100, 10, 1'b0);
        send_knot(256, 100, 10, 1'b1);
        send_knot(0, 100, -1, 1'b0);
        send_knot(256, 100, 10, 1'b1);
        // on the ellipse outside the box, then far outside it
        send_knot(0, 0, 512, 1'b0);
        send_knot(1, 5, 4352, 1'b1);
        send_knot(-16'sd32768, -16'sd32768, 16'sd32767, 1'b0);
        send_knot(16'sd32767, 16'sd32767, 16'sd32767, 1'b1);

        while (knots_sent < TOTAL_KNOTS)
        begin
            calm_sender = (knots_sent >= 700 && knots_sent < 1100);
            random_set();
        end
        knot_ch.valid <= 1'b0;
        @(posedge clk);
        while (board.pending_verdicts.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("checked %0d knots in %0d sets, with random stalls and long receiver hold-offs",
                 board.knots, board.sets);
        $display("verdicts: data-bad %0d, spline-bad %0d, monotone %0d, strictly monotone %0d",
                 board.tally[VERDICT_DATA_BAD], board.tally[VERDICT_SPLINE_BAD],
                 board.tally[VERDICT_MONOTONE], board.tally[VERDICT_STRICT]);
        if (board.errors == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

// ===== files.f =====
design/csmc_pkg.sv
design/csmc_knot_if.sv
design/csmc_verdict_if.sv
design/csmc_datapath.sv
design/csmc_controller.sv
design/cubic_spline_monotonicity_check_unit.sv
tb/sv/csmc_check_pkg.sv
tb/sv/tb.sv
